// ===== design/pyu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyu_pkg
// Shared types, register codes and layout tables of the packed YUV unpacker.
// ----------------------------------------------------------------------------
package pyu_pkg;

    localparam int COMPONENT_BITS_DEFAULT = 8;
    localparam int CHAN_BITS              = 8;
    localparam int NUM_CHANNELS           = 4;
    localparam int QUEUE_DEPTH            = 4;
    localparam int QUEUE_PTR_BITS         = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS         = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_BITS         = 2;
    localparam int CFG_DATA_BITS          = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FORMAT_MODE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLAIN_COUNT = 2'd1;

    localparam logic [2:0] PLAIN_COUNT_RESET = 3'd3;

    typedef enum logic [2:0] {
        FMT_PLAIN = 3'd0,
        FMT_GRAY  = 3'd1,
        FMT_AYUV  = 3'd2,
        FMT_YUV   = 3'd3,
        FMT_YUY2  = 3'd4,
        FMT_UYVY  = 3'd5,
        FMT_I422  = 3'd6,
        FMT_Y411  = 3'd7
    } t_format_mode;

    typedef logic [NUM_CHANNELS-1:0][CHAN_BITS-1:0] t_channels;

    typedef struct packed {
        t_channels chans;
        logic      last;
    } t_pixel;

    typedef struct packed {
        t_channels next_chans;
        logic [2:0] next_phase;
        logic [1:0] num_results;
        t_pixel     pix0;
        t_pixel     pix1;
    } t_decode;

    // Channel that receives the byte at a given phase of a group.
    function automatic logic [1:0] slot_of(input t_format_mode mode,
                                           input logic [2:0] phase);
        logic [1:0] s;
        s = 2'd0;
        case (mode)
            FMT_PLAIN: s = phase[1:0];
            FMT_AYUV: begin
                case (phase[1:0])
                    2'd0:    s = 2'd2;
                    2'd1:    s = 2'd1;
                    2'd2:    s = 2'd0;
                    default: s = 2'd3;
                endcase
            end
            FMT_YUV: begin
                case (phase[1:0])
                    2'd0:    s = 2'd2;
                    2'd1:    s = 2'd1;
                    default: s = 2'd0;
                endcase
            end
            FMT_YUY2: begin
                case (phase[1:0])
                    2'd0:    s = 2'd0;
                    2'd1:    s = 2'd1;
                    2'd2:    s = 2'd3;
                    default: s = 2'd2;
                endcase
            end
            FMT_UYVY: begin
                case (phase[1:0])
                    2'd0:    s = 2'd1;
                    2'd1:    s = 2'd0;
                    2'd2:    s = 2'd2;
                    default: s = 2'd0;
                endcase
            end
            FMT_I422: begin
                case (phase[1:0])
                    2'd0:    s = 2'd0;
                    2'd1:    s = 2'd3;
                    2'd2:    s = 2'd1;
                    default: s = 2'd2;
                endcase
            end
            FMT_Y411: begin
                case (phase)
                    3'd0:    s = 2'd1;
                    3'd2:    s = 2'd3;
                    3'd3:    s = 2'd2;
                    default: s = 2'd0;
                endcase
            end
            default: s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== design/pyu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyu_decode
// Places one component into the channel set and forms the finished pixels.
// ----------------------------------------------------------------------------
module pyu_decode (
    input  pyu_pkg::t_format_mode i_mode,
    input  logic [2:0]            i_plain_count,
    input  logic [2:0]            i_phase,
    input  pyu_pkg::t_channels    i_chans,
    input  logic [7:0]            i_byte,
    output pyu_pkg::t_decode      o_dec
);

    logic [2:0]         w_len;
    logic [2:0]         w_p;
    logic [2:0]         w_p_inc;
    logic [1:0]         w_slot;
    logic               w_emit;
    logic               w_double;
    pyu_pkg::t_channels w_chans;
    pyu_pkg::t_channels w_chans2;

    always_comb begin
        case (i_mode)
            pyu_pkg::FMT_PLAIN: begin
                if (i_plain_count == 3'd0) begin
                    w_len = 3'd1;
                end else if (i_plain_count > 3'd4) begin
                    w_len = 3'd4;
                end else begin
                    w_len = i_plain_count;
                end
            end
            pyu_pkg::FMT_GRAY: w_len = 3'd1;
            pyu_pkg::FMT_YUV:  w_len = 3'd3;
            pyu_pkg::FMT_Y411: w_len = 3'd6;
            default:           w_len = 3'd4;
        endcase

        // A phase outside the group restarts it.
        w_p     = (i_phase >= w_len) ? 3'd0 : i_phase;
        w_p_inc = w_p + 3'd1;
        w_slot  = pyu_pkg::slot_of(i_mode, w_p);

        w_chans = i_chans;
        if (i_mode == pyu_pkg::FMT_GRAY) begin
            w_chans[0] = i_byte;
            w_chans[1] = i_byte;
            w_chans[2] = i_byte;
        end else begin
            w_chans[w_slot] = i_byte;
        end

        case (i_mode)
            pyu_pkg::FMT_PLAIN: w_emit = (w_p_inc == w_len);
            pyu_pkg::FMT_GRAY:  w_emit = 1'b1;
            pyu_pkg::FMT_AYUV:  w_emit = (w_p == 3'd3);
            pyu_pkg::FMT_YUV:   w_emit = (w_p == 3'd2);
            pyu_pkg::FMT_UYVY:  w_emit = (w_p >= 3'd2);
            pyu_pkg::FMT_Y411:  w_emit = (w_p >= 3'd3);
            default:            w_emit = (w_p == 3'd3);
        endcase

        // The YUY2, I422 and Y411 layouts finish two pixels on the chroma byte; the
        // second one takes the scratch luma from channel 3.
        w_double = (w_p == 3'd3) && ((i_mode == pyu_pkg::FMT_YUY2) ||
                   (i_mode == pyu_pkg::FMT_I422) || (i_mode == pyu_pkg::FMT_Y411));

        w_chans2    = w_chans;
        w_chans2[0] = w_chans[3];

        o_dec.next_chans  = w_double ? w_chans2 : w_chans;
        o_dec.next_phase  = (w_p_inc >= w_len) ? 3'd0 : w_p_inc;
        o_dec.num_results = w_double ? 2'd2 : {1'b0, w_emit};
        o_dec.pix0.chans  = w_chans;
        o_dec.pix0.last   = !w_double;
        o_dec.pix1.chans  = w_chans2;
        o_dec.pix1.last   = 1'b1;
    end

endmodule

// ===== design/pyu_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyu_out_queue
// Small result queue taking up to two pixels per cycle and giving one when not stalled.
// ----------------------------------------------------------------------------
module pyu_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_count,
    input  pyu_pkg::t_pixel  i_pix0,
    input  pyu_pkg::t_pixel  i_pix1,
    output logic             o_has_room,
    output logic             o_valid,
    input  logic             i_stall,
    output pyu_pkg::t_pixel  o_pix
);

    localparam int PB = pyu_pkg::QUEUE_PTR_BITS;
    localparam int CB = pyu_pkg::QUEUE_CNT_BITS;

    pyu_pkg::t_pixel r_mem [pyu_pkg::QUEUE_DEPTH];
    logic [PB-1:0]   r_wr_ptr;
    logic [PB-1:0]   n_wr_ptr;
    logic [PB-1:0]   r_rd_ptr;
    logic [PB-1:0]   n_rd_ptr;
    logic [CB-1:0]   r_count;
    logic [CB-1:0]   n_count;
    logic [PB-1:0]   w_wr_ptr1;
    logic            w_pop;

    assign w_pop      = o_valid && !i_stall;
    assign w_wr_ptr1  = r_wr_ptr + PB'(1);
    assign o_valid    = (r_count != '0);
    assign o_has_room = (r_count <= CB'(pyu_pkg::QUEUE_DEPTH - 2));
    assign o_pix      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + PB'(i_push_count);
        n_rd_ptr = r_rd_ptr + PB'(w_pop);
        n_count  = r_count + CB'(i_push_count) - CB'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_pix0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_pix1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/packed_yuv_pixel_unpacker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_yuv_pixel_unpacker_unit
// Assembles four-channel pixels from a stream of packed component bytes.
// ----------------------------------------------------------------------------
// The unit takes one component per request on the input channel and builds
// pixels in the layout chosen by the format_mode register: plain, gray copy,
// AYUV, YUV, YUY2, UYVY, interleaved 4:2:2 or 4:1:1. A request is taken in
// every cycle as long as the four-entry result queue has room for two
// pixels, so a steady stream runs at one byte per clock. Each byte is decoded
// in the cycle it is taken and its pixels enter the queue at that edge; the
// first pixel can leave next cycle. An unstalled queue drains one pixel per
// clock. The chroma byte of YUY2, interleaved 4:2:2 and 4:1:1 groups finishes
// two pixels at once, and the queue absorbs the extra one; averaged over a
// group the output still keeps pace with the input, so the input is stalled
// only when the receiver holds off and the queue fills past two pixels. The
// last_of_run bit marks the final pixel caused by one byte. Configuration
// writes are accepted at any time (ready is always high), should be made
// while the unit is idle, and clear the position within the current group.
// Channels a layout does not write keep their earlier values.
// ----------------------------------------------------------------------------
module packed_yuv_pixel_unpacker_unit #(
    parameter int COMPONENT_BITS = pyu_pkg::COMPONENT_BITS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Component input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [COMPONENT_BITS-1:0]          i_component_byte,
    // Pixel output channel.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [7:0]                         o_channel_0,
    output logic [7:0]                         o_channel_1,
    output logic [7:0]                         o_channel_2,
    output logic [7:0]                         o_channel_3,
    output logic                               o_last_of_run,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pyu_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [pyu_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    pyu_pkg::t_format_mode r_mode;
    logic [2:0]            r_plain_count;
    logic [2:0]            r_phase;
    logic [2:0]            n_phase;
    pyu_pkg::t_channels    r_chans;
    pyu_pkg::t_channels    n_chans;
    pyu_pkg::t_decode      w_dec;
    pyu_pkg::t_pixel       w_head;
    logic                  w_room;
    logic                  w_accept;
    logic                  w_cfg_write;
    logic                  w_cfg_hit;
    logic [1:0]            w_push_count;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;
    // A write beyond the register list is dropped and leaves the phase alone.
    assign w_cfg_hit   = w_cfg_write && ((i_cfg_index == pyu_pkg::CFG_FORMAT_MODE) ||
                                         (i_cfg_index == pyu_pkg::CFG_PLAIN_COUNT));

    assign o_in_stall   = !w_room;
    assign w_accept     = i_in_valid && w_room;
    assign w_push_count = w_accept ? w_dec.num_results : 2'd0;

    // Components wider than the channel registers keep their low byte.
    pyu_decode u_decode (
        .i_mode        (r_mode),
        .i_plain_count (r_plain_count),
        .i_phase       (r_phase),
        .i_chans       (r_chans),
        .i_byte        (i_component_byte[7:0]),
        .o_dec         (w_dec)
    );

    pyu_out_queue u_out_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (w_push_count),
        .i_pix0       (w_dec.pix0),
        .i_pix1       (w_dec.pix1),
        .o_has_room   (w_room),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_pix        (w_head)
    );

    always_comb begin
        n_chans = w_accept ? w_dec.next_chans : r_chans;
        if (w_cfg_hit) begin
            n_phase = 3'd0;
        end else if (w_accept) begin
            n_phase = w_dec.next_phase;
        end else begin
            n_phase = r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= pyu_pkg::FMT_PLAIN;
            r_plain_count <= pyu_pkg::PLAIN_COUNT_RESET;
            r_phase       <= 3'd0;
            r_chans       <= '0;
        end else begin
            r_phase <= n_phase;
            r_chans <= n_chans;
            if (w_cfg_write) begin
                case (i_cfg_index)
                    pyu_pkg::CFG_FORMAT_MODE: begin
                        r_mode <= pyu_pkg::t_format_mode'(i_cfg_data);
                    end
                    pyu_pkg::CFG_PLAIN_COUNT: begin
                        r_plain_count <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_channel_0   = w_head.chans[0];
    assign o_channel_1   = w_head.chans[1];
    assign o_channel_2   = w_head.chans[2];
    assign o_channel_3   = w_head.chans[3];
    assign o_last_of_run = w_head.last;

endmodule
